[rtl/core/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants for the console serial line register block.
// ----------------------------------------------------------------------------
package csl_pkg;

  // Countdown width for the transmitter delay
  localparam int DELAY_WIDTH = 20;

  // Bus and configuration widths
  localparam int ADDR_W     = 16;
  localparam int WORD_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Reset values of the configuration registers
  localparam int unsigned NS_PER_CHAR = 1000000;
  localparam logic [ADDR_W-1:0]      BASE_RESET  = ADDR_W'(65392);
  localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = DELAY_WIDTH'(NS_PER_CHAR / 1000);

  // Register offsets from the base address
  localparam logic [ADDR_W-1:0] OFS_RX_BUF = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] OFS_TX_CSR = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] OFS_TX_BUF = ADDR_W'(6);

  // Status word bit positions
  localparam int ST_DONE_BIT = 7;
  localparam int ST_IE_BIT   = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = CFG_IDX_W'(1);

  // Item kinds
  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_RX     = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_ACK_RX = 3'd4,
    ACT_ACK_TX = 3'd5
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   wdata;
    logic [CHAR_W-1:0]   rx_char;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] rdata;
    logic              tx_valid;
    logic [CHAR_W-1:0] tx_char;
    logic              rx_irq;
    logic              tx_irq;
  } result_t;

  // Status word from DONE and IE
  function automatic logic [WORD_W-1:0] status_word(input logic done, input logic ie);
    logic [WORD_W-1:0] w;
    w = '0;
    w[ST_DONE_BIT] = done;
    w[ST_IE_BIT]   = ie;
    return w;
  endfunction

endpackage

[rtl/core/csl_regs.sv]
// ----------------------------------------------------------------------------
// csl_regs
// Register file and per-word update logic: decodes one word, updates the
// receiver and transmitter state and forms its result in the same cycle.
// ----------------------------------------------------------------------------
module csl_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [csl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          fire,
  input  csl_pkg::item_t                item,
  output csl_pkg::result_t              result
);
  import csl_pkg::*;

  // Configuration
  logic [ADDR_W-1:0]      base_address;
  logic [DELAY_WIDTH-1:0] tx_delay_ticks;

  // Line state
  logic [CHAR_W-1:0]      rx_data, rx_data_next;
  logic                   rx_done, rx_done_next;
  logic                   rx_int_enable, rx_int_enable_next;
  logic [CHAR_W-1:0]      tx_data, tx_data_next;
  logic                   tx_done, tx_done_next;
  logic                   tx_int_enable, tx_int_enable_next;
  logic                   tx_busy, tx_busy_next;
  logic [DELAY_WIDTH-1:0] tx_countdown, tx_countdown_next;
  logic                   rx_request, rx_request_next;
  logic                   tx_request, tx_request_next;

  // Address decode
  logic hit_rx_csr, hit_rx_buf, hit_tx_csr, hit_tx_buf;
  logic new_ie;
  logic [DELAY_WIDTH-1:0] cnt_dec;
  logic [WORD_W-1:0] rdata;
  logic sent;

  assign hit_rx_csr = (item.addr == base_address);
  assign hit_rx_buf = (item.addr == base_address + OFS_RX_BUF);
  assign hit_tx_csr = (item.addr == base_address + OFS_TX_CSR);
  assign hit_tx_buf = (item.addr == base_address + OFS_TX_BUF);
  assign new_ie     = item.wdata[ST_IE_BIT];
  assign cnt_dec    = (tx_countdown != '0) ? tx_countdown - DELAY_WIDTH'(1) : tx_countdown;

  // Next state and result for the word in hand
  always_comb begin
    rx_data_next       = rx_data;
    rx_done_next       = rx_done;
    rx_int_enable_next = rx_int_enable;
    tx_data_next       = tx_data;
    tx_done_next       = tx_done;
    tx_int_enable_next = tx_int_enable;
    tx_busy_next       = tx_busy;
    tx_countdown_next  = tx_countdown;
    rx_request_next    = rx_request;
    tx_request_next    = tx_request;
    rdata              = '0;
    sent               = 1'b0;
    unique case (item.action)
      ACT_READ: begin
        priority if (hit_rx_csr) begin
          rdata = status_word(rx_done, rx_int_enable);
        end else if (hit_rx_buf) begin
          rdata           = WORD_W'(rx_data);
          rx_done_next    = 1'b0;
          rx_request_next = 1'b0;
        end else if (hit_tx_csr) begin
          rdata = status_word(tx_done, tx_int_enable);
        end else if (hit_tx_buf) begin
          rdata = WORD_W'(tx_data);
        end else begin
          rdata = '0;
        end
      end
      ACT_WRITE: begin
        priority if (hit_rx_csr) begin
          if (!new_ie) rx_request_next = 1'b0;
          else if (rx_done && !rx_int_enable) rx_request_next = 1'b1;
          rx_int_enable_next = new_ie;
        end else if (hit_tx_csr) begin
          if (!new_ie) tx_request_next = 1'b0;
          else if (tx_done && !tx_int_enable) tx_request_next = 1'b1;
          tx_int_enable_next = new_ie;
        end else if (hit_tx_buf) begin
          tx_data_next      = item.wdata[CHAR_W-1:0];
          tx_done_next      = 1'b0;
          tx_request_next   = 1'b0;
          tx_busy_next      = 1'b1;
          tx_countdown_next = tx_delay_ticks;
          sent              = 1'b1;
        end else begin
          sent = 1'b0;
        end
      end
      ACT_RX: begin
        rx_data_next = item.rx_char;
        rx_done_next = 1'b1;
        if (rx_int_enable) rx_request_next = 1'b1;
      end
      ACT_TICK: begin
        if (tx_busy) begin
          tx_countdown_next = cnt_dec;
          if (cnt_dec == '0) begin
            tx_busy_next = 1'b0;
            tx_done_next = 1'b1;
            if (tx_int_enable) tx_request_next = 1'b1;
          end
        end
      end
      ACT_ACK_RX: rx_request_next = 1'b0;
      ACT_ACK_TX: tx_request_next = 1'b0;
      default: ;
    endcase
  end

  assign result.rdata    = rdata;
  assign result.tx_valid = sent;
  assign result.tx_char  = sent ? tx_data_next : '0;
  assign result.rx_irq   = rx_request_next;
  assign result.tx_irq   = tx_request_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= BASE_RESET;
      tx_delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE)  base_address   <= cfg_data[ADDR_W-1:0];
      if (cfg_index == CFG_DELAY) tx_delay_ticks <= DELAY_WIDTH'(cfg_data);
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_data       <= '0;
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      tx_data       <= '0;
      tx_done       <= 1'b1;
      tx_int_enable <= 1'b0;
      tx_busy       <= 1'b0;
      tx_countdown  <= '0;
      rx_request    <= 1'b0;
      tx_request    <= 1'b0;
    end else if (fire) begin
      rx_data       <= rx_data_next;
      rx_done       <= rx_done_next;
      rx_int_enable <= rx_int_enable_next;
      tx_data       <= tx_data_next;
      tx_done       <= tx_done_next;
      tx_int_enable <= tx_int_enable_next;
      tx_busy       <= tx_busy_next;
      tx_countdown  <= tx_countdown_next;
      rx_request    <= rx_request_next;
      tx_request    <= tx_request_next;
    end
  end

  // A pending request needs both DONE and IE
  a_rx_req: assert property (@(posedge clk) disable iff (rst)
    rx_request |-> (rx_done && rx_int_enable))
    else $error("rx request without done and ie");
  a_tx_req: assert property (@(posedge clk) disable iff (rst)
    tx_request |-> (tx_done && tx_int_enable))
    else $error("tx request without done and ie");
  // Transmitter never busy and done together
  a_tx_busy: assert property (@(posedge clk) disable iff (rst)
    tx_busy |-> !tx_done)
    else $error("tx busy with done set");
  // An emitted character always leaves the transmitter busy
  a_tx_sent: assert property (@(posedge clk) disable iff (rst)
    (fire && sent) |=> (tx_busy && !tx_request))
    else $error("tx write did not start countdown");

endmodule

[rtl/core/console_serial_line_registers.sv]
// ----------------------------------------------------------------------------
// console_serial_line_registers
// Console serial interface: four bus word registers, a received character
// path and a transmit countdown driven by tick words.
// ----------------------------------------------------------------------------
// Path: input register, one pass of register decode and update, then the
//   result register. Throughput: one word per cycle while m_tready keeps
//   the result register draining; a stalled result holds the input.
// Reset (rst, synchronous): both stages empty, configuration back to
//   base 65392 and delay 1000, transmitter DONE set, all else cleared.
module console_serial_line_registers (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csl_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,  // addr[15:0], wdata[31:16], rx_char[39:32]
  input  logic [2:0]                    s_tuser,  // action[2:0]
  // Result words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata   // rdata[15:0], tx_valid[16],
                                                  // tx_char[24:17], rx_irq[25],
                                                  // tx_irq[26], zero[31:27]
);
  import csl_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action  <= action_t'(s_tuser);
      in_item.addr    <= s_tdata[15:0];
      in_item.wdata   <= s_tdata[31:16];
      in_item.rx_char <= s_tdata[39:32];
    end
  end

  // Register decode and update
  csl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (in_item),
    .result    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_res.tx_irq, out_res.rx_irq, out_res.tx_char,
                     out_res.tx_valid, out_res.rdata};

endmodule

[test/console_serial_line_registers_tb.sv]
// ----------------------------------------------------------------------------
// console_serial_line_registers_tb
// Self-checking bench for the console serial line register block. A short
// stimulus table covers reset values, address decode, the interrupt enable
// rules, transmit reload, zero delay and base wrap. Random bus traffic then
// runs under several base/delay settings and handshake idling mixes. Every
// result word is checked field by field against a typed-in value or a
// cycle-free model of the four registers kept in this bench.
// ----------------------------------------------------------------------------
module console_serial_line_registers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csl_pkg::*;

  // Item kinds outside the package enum: no effect on the block
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]        act;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    logic [CHAR_W-1:0] ch;
  } line_word_t;

  // Stimulus table row: a bus word or a register write
  typedef struct {
    logic                  is_cfg;
    line_word_t            w;
    logic                  pinned;
    logic [WORD_W-1:0]     rdata_want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } table_row_t;

  // Typed-in expectation travelling with each word sent
  typedef struct {
    logic    pinned;
    result_t want;
  } pin_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;

  console_serial_line_registers dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #1 clk = ~clk;

  // Register model state
  logic [ADDR_W-1:0]      line_base;
  logic [DELAY_WIDTH-1:0] line_delay;
  logic [CHAR_W-1:0]      rbuf, xbuf;
  logic                   rdone, rie, rreq;
  logic                   xdone, xie, xreq, xbusy;
  logic [DELAY_WIDTH-1:0] xcount;

  result_t    due_results[$];
  pin_t       pin_q[$];
  table_row_t rows[$];
  int         sent_count = 0;
  int         got_count = 0;
  int         err_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  function automatic void model_reset();
    line_base  = BASE_RESET;
    line_delay = DELAY_RESET;
    rbuf = '0; rdone = 1'b0; rie = 1'b0; rreq = 1'b0;
    xbuf = '0; xdone = 1'b1; xie = 1'b0; xreq = 1'b0;
    xbusy = 1'b0; xcount = '0;
  endfunction

  // Request after a status write: IE low drops it, a rising IE over DONE raises it
  function automatic logic req_after_ie(input logic new_ie, done, old_ie, req);
    if (!new_ie) return 1'b0;
    if (done && !old_ie) return 1'b1;
    return req;
  endfunction

  // Advance the register model by one word and give its result
  function automatic result_t console_next(input line_word_t w);
    result_t           r;
    logic [ADDR_W-1:0] rx_buf_a, tx_csr_a, tx_buf_a;
    r = '0;
    rx_buf_a = line_base + OFS_RX_BUF;
    tx_csr_a = line_base + OFS_TX_CSR;
    tx_buf_a = line_base + OFS_TX_BUF;
    case (w.act)
      ACT_READ: begin
        if (w.addr == line_base) begin
          r.rdata[ST_DONE_BIT] = rdone;
          r.rdata[ST_IE_BIT]   = rie;
        end else if (w.addr == rx_buf_a) begin
          r.rdata = {8'h00, rbuf};
          rdone = 1'b0;
          rreq  = 1'b0;
        end else if (w.addr == tx_csr_a) begin
          r.rdata[ST_DONE_BIT] = xdone;
          r.rdata[ST_IE_BIT]   = xie;
        end else if (w.addr == tx_buf_a) begin
          r.rdata = {8'h00, xbuf};
        end
      end
      ACT_WRITE: begin
        if (w.addr == line_base) begin
          rreq = req_after_ie(w.wdata[ST_IE_BIT], rdone, rie, rreq);
          rie  = w.wdata[ST_IE_BIT];
        end else if (w.addr == tx_csr_a) begin
          xreq = req_after_ie(w.wdata[ST_IE_BIT], xdone, xie, xreq);
          xie  = w.wdata[ST_IE_BIT];
        end else if (w.addr == tx_buf_a) begin
          xbuf   = w.wdata[CHAR_W-1:0];
          xdone  = 1'b0;
          xreq   = 1'b0;
          xbusy  = 1'b1;
          xcount = line_delay;
          r.tx_valid = 1'b1;
          r.tx_char  = xbuf;
        end
      end
      ACT_RX: begin
        rbuf  = w.ch;
        rdone = 1'b1;
        if (rie) rreq = 1'b1;
      end
      ACT_TICK: begin
        if (xbusy) begin
          if (xcount != '0) xcount = xcount - 1'b1;
          if (xcount == '0) begin
            xbusy = 1'b0;
            xdone = 1'b1;
            if (xie) xreq = 1'b1;
          end
        end
      end
      ACT_ACK_RX: rreq = 1'b0;
      ACT_ACK_TX: xreq = 1'b0;
      default: ;
    endcase
    r.rx_irq = rreq;
    r.tx_irq = xreq;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want, got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Result, register write and input word monitor
  always @(posedge clk) begin
    result_t    exp_r;
    line_word_t w;
    pin_t       p;
    result_t    pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_count++;
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: result word %h with none expected", $time, m_tdata);
        end else begin
          exp_r = due_results.pop_front();
          check_field("rdata", exp_r.rdata, m_tdata[15:0]);
          check_field("tx_valid", 16'(exp_r.tx_valid), 16'(m_tdata[16]));
          check_field("tx_char", 16'(exp_r.tx_char), 16'(m_tdata[24:17]));
          check_field("rx_irq", 16'(exp_r.rx_irq), 16'(m_tdata[25]));
          check_field("tx_irq", 16'(exp_r.tx_irq), 16'(m_tdata[26]));
          check_field("pad", '0, 16'(m_tdata[31:27]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) line_base = cfg_data[ADDR_W-1:0];
        else if (cfg_index == CFG_DELAY) line_delay = DELAY_WIDTH'(cfg_data);
      end
      if (s_tvalid && s_tready) begin
        w.act   = s_tuser;
        w.addr  = s_tdata[15:0];
        w.wdata = s_tdata[31:16];
        w.ch    = s_tdata[39:32];
        p = pin_q.pop_front();
        pred = console_next(w);
        due_results.push_back(p.pinned ? p.want : pred);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_word(input line_word_t w, input logic pinned, input result_t want);
    pin_t p;
    p.pinned = pinned;
    p.want   = want;
    pin_q.push_back(p);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.act;
    s_tdata  <= {w.ch, w.wdata, w.addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (got_count != sent_count) @(posedge clk);
  endtask

  task automatic quiesce();
    drain();
    repeat (3) @(posedge clk);
  endtask

  // cfg_valid is left high when another register write follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  function automatic table_row_t item_row(input logic [2:0] act, input logic [15:0] addr,
                                          input logic [15:0] wdata, input logic [7:0] ch);
    table_row_t r;
    r = '{is_cfg: 1'b0, w: '{act, addr, wdata, ch}, pinned: 1'b0, rdata_want: '0,
          idx: '0, val: '0};
    return r;
  endfunction

  // Read whose whole result is obvious (no requests pending)
  function automatic table_row_t read_pin(input logic [15:0] addr, input logic [15:0] rd);
    table_row_t r;
    r = item_row(ACT_READ, addr, 16'h0000, 8'h00);
    r.pinned = 1'b1;
    r.rdata_want = rd;
    return r;
  endfunction

  function automatic table_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    table_row_t r;
    r = item_row(ACT_READ, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Mostly register hits, some near misses on odd addresses, some anywhere
  function automatic line_word_t random_word();
    line_word_t w;
    int         k;
    k = $urandom_range(99);
    if (k < 24)      w.act = ACT_READ;
    else if (k < 48) w.act = ACT_WRITE;
    else if (k < 60) w.act = ACT_RX;
    else if (k < 88) w.act = ACT_TICK;
    else if (k < 94) w.act = ACT_ACK_RX;
    else             w.act = ACT_ACK_TX;
    k = $urandom_range(99);
    if (k < 78)      w.addr = line_base + 16'(2 * $urandom_range(0, 3));
    else if (k < 88) w.addr = line_base + 16'($urandom_range(0, 7) | 1);
    else             w.addr = 16'($urandom);
    w.wdata = 16'($urandom);
    w.ch    = 8'($urandom);
    return w;
  endfunction

  task automatic run_random(input logic [15:0] base, input logic [19:0] delay,
                            input int in_idle, input int out_stall, input int n);
    quiesce();
    write_reg(CFG_BASE, 20'(base), 1'b0);
    write_reg(CFG_DELAY, delay, 1'b1);
    idle_pct  = in_idle;
    stall_pct = out_stall;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && in_idle != 0) drain();
      send_word(random_word(), 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    table_row_t r;
    result_t    want;
    model_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values and decode at the reset base
    rows.push_back(read_pin(16'hFF70, 16'h0000));
    rows.push_back(read_pin(16'hFF74, 16'h0080));
    rows.push_back(read_pin(16'hFF72, 16'h0000));
    rows.push_back(read_pin(16'hFF76, 16'h0000));
    rows.push_back(read_pin(16'hFF71, 16'h0000));
    // receive buffer is read-only
    rows.push_back(item_row(ACT_WRITE, 16'hFF72, 16'hFFFF, 8'h00));
    // character lands, then another overwrites it while DONE is set
    rows.push_back(item_row(ACT_RX, 16'h0000, 16'h0000, 8'hFF));
    rows.push_back(item_row(ACT_RX, 16'hFFFF, 16'hFFFF, 8'h00));
    // IE over DONE raises a request, ack drops it, IE clear and set again
    rows.push_back(item_row(ACT_WRITE, 16'hFF70, 16'h0040, 8'h00));
    rows.push_back(item_row(ACT_ACK_RX, 16'h0000, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_WRITE, 16'hFF70, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_WRITE, 16'hFF70, 16'hFFFF, 8'h00));
    rows.push_back(item_row(ACT_READ, 16'hFF72, 16'h0000, 8'h00));
    // transmitter: IE over DONE, send, reload while busy, tick
    rows.push_back(item_row(ACT_WRITE, 16'hFF74, 16'h0040, 8'h00));
    rows.push_back(item_row(ACT_WRITE, 16'hFF76, 16'h00A5, 8'h00));
    rows.push_back(item_row(ACT_WRITE, 16'hFF76, 16'hFF5A, 8'h00));
    rows.push_back(item_row(ACT_TICK, 16'h0000, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_READ, 16'hFF76, 16'h0000, 8'h00));
    // spare kinds, unmatched write, ack with nothing pending
    rows.push_back(item_row(ACT_SPARE6, 16'hFF76, 16'hFFFF, 8'hFF));
    rows.push_back(item_row(ACT_SPARE7, 16'hFF70, 16'hFFFF, 8'hFF));
    rows.push_back(item_row(ACT_WRITE, 16'h0000, 16'hFFFF, 8'h00));
    rows.push_back(item_row(ACT_ACK_TX, 16'h0000, 16'h0000, 8'h00));
    // zero delay and a base whose upper registers wrap past 0xFFFF
    rows.push_back(cfg_row(CFG_DELAY, 20'd0));
    rows.push_back(cfg_row(CFG_BASE, 20'hFFFE));
    rows.push_back(item_row(ACT_WRITE, 16'h0004, 16'h00C3, 8'h00));
    rows.push_back(item_row(ACT_TICK, 16'h0000, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_READ, 16'h0002, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_TICK, 16'h0000, 16'h0000, 8'h00));
    rows.push_back(item_row(ACT_READ, 16'h0000, 16'h0000, 8'h00));

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) begin
        if (i == 0 || !rows[i-1].is_cfg) quiesce();
        write_reg(r.idx, r.val, (i == rows.size() - 1) || !rows[i+1].is_cfg);
      end else begin
        want = '0;
        want.rdata = r.rdata_want;
        send_word(r.w, r.pinned, want);
      end
    end

    // Random traffic under several settings and idling mixes
    run_random(16'hFF70, 20'd3, 0, 0, 305);
    run_random(16'h0000, 20'd0, 45, 0, 305);
    run_random(16'hFFFE, 20'd1, 0, 45, 305);
    run_random(16'h1234, 20'hFFFFF, 32, 32, 305);
    run_random(16'hFFFA, 20'd7, 32, 32, 305);
    run_random(16'h8000, 20'd2, 0, 0, 305);

    drain();
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      err_count += due_results.size();
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    if (err_count == 0) begin
      $display("console_serial_line_registers_tb: clean");
    end else begin
      $display("console_serial_line_registers_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("console_serial_line_registers_tb: errors");
    $finish;
  end

endmodule

[sim.f]
rtl/core/csl_pkg.sv
rtl/core/csl_regs.sv
rtl/core/console_serial_line_registers.sv
test/console_serial_line_registers_tb.sv
